### design/sdc_pkg.sv
`timescale 1ns / 1ps

package sdc_pkg;

    // time base and sensor constants
    localparam int TICKS_PER_SECOND    = 100;
    localparam int SAMPLE_PERIOD_TICKS = 50;
    localparam int SYNC_PERIOD_TICKS   = 60000;
    localparam int CONFIRM_TICKS       = 100;
    localparam int COUNTS_PER_CM       = 116;

    localparam int SUB_W    = $clog2(TICKS_PER_SECOND + 1);
    localparam int SAMPLE_W = $clog2(SAMPLE_PERIOD_TICKS + 1);
    localparam int SYNC_W   = $clog2(SYNC_PERIOD_TICKS + 1);

    localparam int SECS_PER_MIN    = 60;
    localparam int MINS_PER_HOUR   = 60;
    localparam int HOURS_PER_DAY   = 24;
    localparam int DONE_CLEAR_HOUR = 1;
    localparam int MOD_W           = 11;
    localparam int DIST_MAX        = 1023;

    // exact reciprocal for a 16-bit dividend: shift = 16 + ceil(log2 d), multiplier rounded up
    localparam int ECHO_W     = 16;
    localparam int CM_SHIFT   = ECHO_W + $clog2(COUNTS_PER_CM);
    localparam int CM_RECIP   = ((1 << CM_SHIFT) + COUNTS_PER_CM - 1) / COUNTS_PER_CM;
    localparam int CM_PROD_W  = ECHO_W + 18;

    localparam logic [3:0] ALARM_A_BIT = 4'h1;
    localparam logic [3:0] ALARM_B_BIT = 4'h2;
    localparam logic [3:0] ALARM_C_BIT = 4'h4;
    localparam logic [3:0] ALARM_D_BIT = 4'h8;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ECHO = 2'd1;
    localparam logic [1:0] CMD_SET  = 2'd2;

    localparam logic [2:0] CFG_ALARM_A    = 3'd0;
    localparam logic [2:0] CFG_ALARM_B    = 3'd1;
    localparam logic [2:0] CFG_ALARM_C    = 3'd2;
    localparam logic [2:0] CFG_ALARM_D    = 3'd3;
    localparam logic [2:0] CFG_NEAR_LIMIT = 3'd4;
    localparam logic [2:0] CFG_TIMED_RUN  = 3'd5;
    localparam logic [2:0] CFG_SNACK_RUN  = 3'd6;
    localparam logic [2:0] CFG_REST       = 3'd7;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_SEEN  = 2'd1,
        MODE_TIMED = 2'd2,
        MODE_SNACK = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] echo_width;
        logic        echo_timeout;
        logic [4:0]  new_hours;
        logic [5:0]  new_minutes;
        logic [5:0]  new_seconds;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  mode;
        logic        motor_on;
        logic        cooldown_active;
        logic [4:0]  clock_hours;
        logic [5:0]  clock_minutes;
        logic [5:0]  clock_seconds;
        logic [9:0]  range_cm;
        logic        sample_request;
        logic        sync_request;
        logic [3:0]  alarms_done;
    } t_out_word;

endpackage

### design/scheduled_dispense_controller.sv
`timescale 1ns / 1ps

// Feeder controller. Three channels, all valid/ready:
//   in  : one word per event (tick, echo measurement, time set), i_in_word
//   out : one status word per input word, o_out_word
//   cfg : register writes (index, data); always ready, write only while idle
// Every input word yields exactly one status word, in order. A word accepted
// into the input register passes the update logic and is then written to the
// output register.
// Throughput is one word per cycle while the output is not stalled; the
// feedback path that sets it is the state update, which finishes for each
// word in the cycle it leaves the input register.
// When the receiver stalls, the output register holds its word, the input
// register still takes one more word, and then o_in_ready drops until the
// output is taken. Reset clears the clock, counters, stamps and mode (idle,
// cooldown active at start) and loads the default alarm times and run lengths.
module scheduled_dispense_controller
    import sdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration
    logic [MOD_W-1:0] r_alarm_a, r_alarm_b, r_alarm_c, r_alarm_d;
    logic [9:0]       r_near;
    logic [15:0]      r_timed_ticks, r_snack_ticks, r_rest_ticks;

    // pipeline
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      advance;

    // state
    logic [31:0]         r_tick, n_tick;
    logic [SUB_W-1:0]    r_sub, n_sub;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic [SYNC_W-1:0]   r_sync, n_sync;
    logic [4:0]          r_hour, n_hour;
    logic [5:0]          r_min, n_min;
    logic [5:0]          r_sec, n_sec;
    t_mode               r_mode, n_mode;
    logic [3:0]          r_done, n_done;
    logic [31:0]         r_seen, n_seen;
    logic [31:0]         r_run, n_run;
    logic [31:0]         r_rest, n_rest;
    logic [9:0]          r_dist, n_dist;
    logic                sample_req, sync_req;
    t_out_word           n_out;

    // incremented values, one bit wider where out-of-range loads can carry
    logic [SUB_W-1:0]    sub_inc;
    logic [SAMPLE_W:0]   sample_inc;
    logic [SYNC_W:0]     sync_inc;
    logic [6:0]          sec_inc, min_inc;
    logic [5:0]          hour_inc;
    logic [31:0]         rest_gap;

    logic [CM_PROD_W-1:0] echo_prod;
    logic [ECHO_W-1:0]    echo_quot;
    logic [9:0]           echo_cm;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    assign sub_inc    = r_sub + 1'b1;
    assign sample_inc = {1'b0, r_sample} + 1'b1;
    assign sync_inc   = {1'b0, r_sync} + 1'b1;
    assign sec_inc    = {1'b0, r_sec} + 7'd1;
    assign min_inc    = {1'b0, r_min} + 7'd1;
    assign hour_inc   = {1'b0, r_hour} + 6'd1;
    assign rest_gap   = r_tick - r_rest;

    // distance = width / counts_per_cm by reciprocal multiply, exact for 16 bits
    assign echo_prod = CM_PROD_W'(r_in_word.echo_width) * CM_PROD_W'(CM_RECIP);
    assign echo_quot = ECHO_W'(echo_prod >> CM_SHIFT);
    assign echo_cm   = (echo_quot > ECHO_W'(DIST_MAX)) ? 10'(DIST_MAX) : echo_quot[9:0];

    // next state
    always_comb begin
        logic [MOD_W-1:0] v_mod;
        logic [3:0]       v_bit;
        n_tick     = r_tick;
        n_sub      = r_sub;
        n_sample   = r_sample;
        n_sync     = r_sync;
        n_hour     = r_hour;
        n_min      = r_min;
        n_sec      = r_sec;
        n_mode     = r_mode;
        n_done     = r_done;
        n_seen     = r_seen;
        n_run      = r_run;
        n_rest     = r_rest;
        n_dist     = r_dist;
        sample_req = 1'b0;
        sync_req   = 1'b0;
        v_mod      = '0;
        v_bit      = '0;

        case (r_in_word.cmd)
            CMD_TICK: begin
                n_tick = r_tick + 32'd1;
                if (sample_inc >= (SAMPLE_W+1)'(SAMPLE_PERIOD_TICKS)) begin
                    n_sample   = '0;
                    sample_req = 1'b1;
                end else begin
                    n_sample = sample_inc[SAMPLE_W-1:0];
                end
                if (sync_inc >= (SYNC_W+1)'(SYNC_PERIOD_TICKS)) begin
                    n_sync   = '0;
                    sync_req = 1'b1;
                end else begin
                    n_sync = sync_inc[SYNC_W-1:0];
                end
                if (sub_inc >= SUB_W'(TICKS_PER_SECOND)) begin
                    n_sub = '0;
                    if (sec_inc < 7'(SECS_PER_MIN)) begin
                        n_sec = sec_inc[5:0];
                    end else begin
                        n_sec = '0;
                        if (min_inc < 7'(MINS_PER_HOUR)) begin
                            n_min = min_inc[5:0];
                        end else begin
                            n_min = '0;
                            if (hour_inc >= 6'(HOURS_PER_DAY)) begin
                                n_hour = '0;
                            end else begin
                                n_hour = hour_inc[4:0];
                            end
                            // day rollover of the served flags at 01:00
                            if (n_hour == 5'(DONE_CLEAR_HOUR)) begin
                                n_done = '0;
                            end
                        end
                        v_mod = MOD_W'(n_hour) * MOD_W'(MINS_PER_HOUR) + MOD_W'(n_min);
                        if (v_mod == r_alarm_a) begin
                            v_bit = ALARM_A_BIT;
                        end else if (v_mod == r_alarm_b) begin
                            v_bit = ALARM_B_BIT;
                        end else if (v_mod == r_alarm_c) begin
                            v_bit = ALARM_C_BIT;
                        end else if (v_mod == r_alarm_d) begin
                            v_bit = ALARM_D_BIT;
                        end
                        if (v_bit != '0 && (n_done & v_bit) == '0 && n_mode == MODE_IDLE) begin
                            n_done = n_done | v_bit;
                            n_mode = MODE_TIMED;
                            n_run  = n_tick;
                        end
                    end
                end else begin
                    n_sub = sub_inc;
                end
            end
            CMD_ECHO: begin
                // echoes are ignored while the motor runs
                if (r_mode == MODE_IDLE || r_mode == MODE_SEEN) begin
                    if (r_in_word.echo_timeout) begin
                        n_dist = '0;
                    end else begin
                        n_dist = echo_cm;
                        if (echo_cm != '0 && echo_cm < r_near) begin
                            if (rest_gap >= {16'd0, r_rest_ticks} && r_mode == MODE_IDLE) begin
                                n_mode = MODE_SEEN;
                                n_seen = r_tick;
                            end
                        end else if (r_mode == MODE_SEEN) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                end
            end
            CMD_SET: begin
                n_hour = r_in_word.new_hours;
                n_min  = r_in_word.new_minutes;
                n_sec  = r_in_word.new_seconds;
            end
            default: ;
        endcase

        // mode timers, evaluated once after every word
        case (n_mode)
            MODE_SEEN: begin
                if (n_tick - n_seen >= 32'(CONFIRM_TICKS)) begin
                    n_mode = MODE_SNACK;
                    n_run  = n_tick;
                end
            end
            MODE_TIMED: begin
                if (n_tick - n_run >= {16'd0, r_timed_ticks}) begin
                    n_mode = MODE_IDLE;
                    n_dist = '0;
                end
            end
            MODE_SNACK: begin
                if (n_tick - n_run >= {16'd0, r_snack_ticks}) begin
                    n_mode = MODE_IDLE;
                    n_rest = n_tick;
                    n_dist = '0;
                end
            end
            default: ;
        endcase
    end

    // status word
    always_comb begin
        n_out.mode            = n_mode;
        n_out.motor_on        = (n_mode == MODE_TIMED) || (n_mode == MODE_SNACK);
        n_out.cooldown_active = (n_tick - n_rest) < {16'd0, r_rest_ticks};
        n_out.clock_hours     = n_hour;
        n_out.clock_minutes   = n_min;
        n_out.clock_seconds   = n_sec;
        n_out.range_cm        = n_dist;
        n_out.sample_request  = sample_req;
        n_out.sync_request    = sync_req;
        n_out.alarms_done     = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tick      <= '0;
            r_sub       <= '0;
            r_sample    <= '0;
            r_sync      <= '0;
            r_hour      <= '0;
            r_min       <= '0;
            r_sec       <= '0;
            r_mode      <= MODE_IDLE;
            r_done      <= '0;
            r_seen      <= '0;
            r_run       <= '0;
            r_rest      <= '0;
            r_dist      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_tick      <= n_tick;
                r_sub       <= n_sub;
                r_sample    <= n_sample;
                r_sync      <= n_sync;
                r_hour      <= n_hour;
                r_min       <= n_min;
                r_sec       <= n_sec;
                r_mode      <= n_mode;
                r_done      <= n_done;
                r_seen      <= n_seen;
                r_run       <= n_run;
                r_rest      <= n_rest;
                r_dist      <= n_dist;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_a     <= 11'd360;
            r_alarm_b     <= 11'd774;
            r_alarm_c     <= 11'd1080;
            r_alarm_d     <= 11'd0;
            r_near        <= 10'd20;
            r_timed_ticks <= 16'd700;
            r_snack_ticks <= 16'd300;
            r_rest_ticks  <= 16'd300;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALARM_A:    r_alarm_a     <= i_cfg_data[MOD_W-1:0];
                CFG_ALARM_B:    r_alarm_b     <= i_cfg_data[MOD_W-1:0];
                CFG_ALARM_C:    r_alarm_c     <= i_cfg_data[MOD_W-1:0];
                CFG_ALARM_D:    r_alarm_d     <= i_cfg_data[MOD_W-1:0];
                CFG_NEAR_LIMIT: r_near        <= i_cfg_data[9:0];
                CFG_TIMED_RUN:  r_timed_ticks <= i_cfg_data;
                CFG_SNACK_RUN:  r_snack_ticks <= i_cfg_data;
                CFG_REST:       r_rest_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule
